/* hw/rtl/gdds_pkg.sv */
// Shared types, constants and calendar helpers for the Gregorian day span block.
// Used by gdds_div, the top level and the testbench; depends on nothing else.
package gdds_pkg;

	localparam int DATE_W  = 27;
	localparam int COUNT_W = 22;
	localparam int YEAR_W  = 14;
	localparam int FIELD_W = 7;
	localparam int REM_W   = 9;
	localparam int LEN_W   = 9;

	// Scaled reciprocal of 100: floor(x / 100) is (x * RECIP_100) >> RECIP_SHIFT
	// for every dividend below 2^30.
	localparam int                 RECIP_W     = 28;
	localparam int                 RECIP_SHIFT = 34;
	localparam logic [RECIP_W-1:0] RECIP_100   = 28'd171798692;

	localparam logic [REM_W-1:0]   DIV_BY_100      = 9'd100;
	localparam logic [REM_W-1:0]   CYCLE_YEARS     = 9'd400;
	localparam logic [REM_W-1:0]   CYCLE_LAST_YEAR = 9'd399;
	localparam logic [FIELD_W-1:0] MONTHS_PER_YEAR = 7'd12;
	localparam logic [FIELD_W-1:0] FEBRUARY        = 7'd2;

	typedef struct packed {
		logic              start;
		logic [DATE_W-1:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATE_W-1:0] quotient;
		logic [REM_W-1:0]  remainder;
	} div_rsp_t;

	// Leap test from the year's position in the 400-year cycle.
	function automatic logic is_leap(input logic [REM_W-1:0] c400);
		logic century;
		century = c400 inside {9'd100, 9'd200, 9'd300};
		return (c400[1:0] == 2'd0) && !century;
	endfunction

	function automatic logic [LEN_W-1:0] month_len(input logic [FIELD_W-1:0] m,
		input logic leap);
		logic [LEN_W-1:0] len;
		len = 9'd30;
		case (m)
			FEBRUARY: begin
				len = leap ? 9'd29 : 9'd28;
			end
			default: begin
				if (m inside {7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12})
					len = 9'd31;
				else
					len = 9'd30;
			end
		endcase
		return len;
	endfunction

	function automatic logic [LEN_W-1:0] year_len(input logic leap);
		return leap ? 9'd366 : 9'd365;
	endfunction

endpackage

/* hw/rtl/gdds_div.sv */
// Divide-by-100 unit: one reciprocal multiply; the result is ready in the next cycle.
// Depends on gdds_pkg for the request and response types and the reciprocal constant.
module gdds_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gdds_pkg::div_req_t req,
	output gdds_pkg::div_rsp_t rsp
);
	import gdds_pkg::*;

	localparam int PROD_W = DATE_W + RECIP_W;

	logic [DATE_W-1:0] dividend_q;
	logic [DATE_W-1:0] quot_q;
	logic              done_q;

	logic [PROD_W-1:0] product;
	logic [DATE_W-1:0] quot_next;
	logic [REM_W-1:0]  rem;

	// The remainder is below 100, so its low bits of the difference are exact.
	always_comb begin
		product   = PROD_W'(req.dividend) * PROD_W'(RECIP_100);
		quot_next = DATE_W'(product[PROD_W-1:RECIP_SHIFT]);
		rem       = REM_W'(dividend_q - quot_q * DATE_W'(DIV_BY_100));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= req.start;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dividend_q <= req.dividend;
			quot_q     <= quot_next;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quot_q;
	assign rsp.remainder = rem;

endmodule

/* hw/rtl/gregorian_date_day_span_top.sv */
// Top level of the Gregorian day span block: sequencer, shared accumulator, output register.
// Depends on gdds_pkg and instantiates gdds_div.
//
// The block takes a request of two dates, each packed as the decimal number
// YYYYMMDD, and returns the number of days from the earlier date to the later
// one with both ends counted. Both channels use valid and ready; a request or
// a result moves at a rising edge where both are high.
//
// One request is worked at a time. After acceptance the dates are ordered and
// split into day, month and year by five passes through a divide-by-100 unit.
// When the years differ, a single accumulator then walks the rest of the first
// year month by month and every year between the two dates; in all cases it
// walks the months of the final year. For the widest inputs the year walk
// dominates. Input ready is high only while the sequencer is idle, so a new
// request is taken only once the last one has left the sequencer.
//
// The result sits in an output register. A new request is accepted while a
// finished result still waits; if the receiver stalls, the next result holds
// the sequencer in its last step until the register frees up. Reset clears
// the sequencer and drops the result valid; no memory needs clearing.
module gregorian_date_day_span_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gdds_pkg::DATE_W-1:0]   first_date,
	input  logic [gdds_pkg::DATE_W-1:0]   second_date,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gdds_pkg::COUNT_W-1:0]  day_count
);
	import gdds_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DA1  = 4'd1;
	localparam logic [3:0] ST_DA2  = 4'd2;
	localparam logic [3:0] ST_DB1  = 4'd3;
	localparam logic [3:0] ST_DB2  = 4'd4;
	localparam logic [3:0] ST_DY   = 4'd5;
	localparam logic [3:0] ST_HEAD = 4'd6;
	localparam logic [3:0] ST_MON1 = 4'd7;
	localparam logic [3:0] ST_YEAR = 4'd8;
	localparam logic [3:0] ST_MON2 = 4'd9;
	localparam logic [3:0] ST_FIN  = 4'd10;

	logic [3:0]          state_q;
	logic [DATE_W-1:0]   late_q;
	logic [FIELD_W-1:0]  d1_q, m1_q, d2_q, m2_q, m_q;
	logic [YEAR_W-1:0]   y1_q, y2_q;
	logic [REM_W-1:0]    c400_q;
	logic [COUNT_W-1:0]  sum_q;
	logic                out_valid_q;
	logic [COUNT_W-1:0]  count_q;

	div_req_t            div_req;
	div_rsp_t            div_rsp;

	logic                accept;
	logic                swap;
	logic                leap;
	logic [REM_W-1:0]    c400_inc;
	logic [COUNT_W-1:0]  addend;
	logic                add_en;
	logic [COUNT_W-1:0]  sum_next;
	logic                fin_go;

	gdds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign swap      = first_date > second_date;
	assign leap      = is_leap(c400_q);
	assign c400_inc  = (c400_q == CYCLE_LAST_YEAR) ? '0 : c400_q + REM_W'(1);
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign day_count = count_q;

	// Divider requests: a date's second split takes the quotient of its first directly.
	// The last one divides the earlier year by 100 to place it in the 400-year cycle.
	always_comb begin
		div_req = '0;
		case (state_q)
			ST_IDLE: begin
				div_req.start    = accept;
				div_req.dividend = swap ? second_date : first_date;
			end
			ST_DA1: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = div_rsp.quotient;
			end
			ST_DA2: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = late_q;
			end
			ST_DB1: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = div_rsp.quotient;
			end
			ST_DB2: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = DATE_W'(y1_q);
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	// The one accumulator adder and the operand it takes in each step.
	always_comb begin
		addend = '0;
		add_en = 1'b0;
		case (state_q)
			ST_HEAD: begin
				addend = COUNT_W'(month_len(m1_q, leap)) - COUNT_W'(d1_q) + COUNT_W'(1);
				add_en = 1'b1;
			end
			ST_MON1: begin
				addend = COUNT_W'(month_len(m_q, leap));
				add_en = (m_q <= MONTHS_PER_YEAR);
			end
			ST_YEAR: begin
				addend = COUNT_W'(year_len(leap));
				add_en = (y1_q < y2_q);
			end
			ST_MON2: begin
				addend = COUNT_W'(month_len(m_q, leap));
				add_en = (m_q < m2_q);
			end
			ST_FIN: begin
				// The day difference is added once, when the result is posted.
				addend = COUNT_W'(d2_q) - COUNT_W'(d1_q) + COUNT_W'(1);
				add_en = fin_go;
			end
			default: begin
				addend = '0;
				add_en = 1'b0;
			end
		endcase
		sum_next = sum_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= fin_go || (out_valid_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_DA1;
				end
				ST_DA1: begin
					if (div_rsp.done)
						state_q <= ST_DA2;
				end
				ST_DA2: begin
					if (div_rsp.done)
						state_q <= ST_DB1;
				end
				ST_DB1: begin
					if (div_rsp.done)
						state_q <= ST_DB2;
				end
				ST_DB2: begin
					if (div_rsp.done)
						state_q <= ST_DY;
				end
				ST_DY: begin
					if (div_rsp.done)
						state_q <= (y1_q < y2_q) ? ST_HEAD : ST_MON2;
				end
				ST_HEAD: begin
					state_q <= ST_MON1;
				end
				ST_MON1: begin
					if (!add_en)
						state_q <= ST_YEAR;
				end
				ST_YEAR: begin
					if (!add_en)
						state_q <= ST_MON2;
				end
				ST_MON2: begin
					if (!add_en)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the walk; none of them needs a reset value.
	always_ff @(posedge clk) begin
		if (accept)
			late_q <= swap ? first_date : second_date;
		if (add_en)
			sum_q <= sum_next;
		if (fin_go)
			count_q <= sum_next;
		case (state_q)
			ST_DA1: begin
				if (div_rsp.done)
					d1_q <= div_rsp.remainder[FIELD_W-1:0];
			end
			ST_DA2: begin
				if (div_rsp.done) begin
					m1_q <= div_rsp.remainder[FIELD_W-1:0];
					y1_q <= div_rsp.quotient[YEAR_W-1:0];
				end
			end
			ST_DB1: begin
				if (div_rsp.done)
					d2_q <= div_rsp.remainder[FIELD_W-1:0];
			end
			ST_DB2: begin
				if (div_rsp.done) begin
					m2_q <= div_rsp.remainder[FIELD_W-1:0];
					y2_q <= div_rsp.quotient[YEAR_W-1:0];
				end
			end
			ST_DY: begin
				// Year mod 400 is (year / 100 mod 4) hundreds plus year mod 100.
				if (div_rsp.done) begin
					c400_q <= REM_W'(div_rsp.quotient[1:0]) * DIV_BY_100 + div_rsp.remainder;
					sum_q  <= '0;
					m_q    <= m1_q;
				end
			end
			ST_HEAD: begin
				m_q <= m1_q + FIELD_W'(1);
			end
			ST_MON1: begin
				if (add_en) begin
					m_q <= m_q + FIELD_W'(1);
				end else begin
					y1_q   <= y1_q + YEAR_W'(1);
					c400_q <= c400_inc;
				end
			end
			ST_YEAR: begin
				if (add_en) begin
					y1_q   <= y1_q + YEAR_W'(1);
					c400_q <= c400_inc;
				end else begin
					m_q  <= FIELD_W'(1);
					d1_q <= FIELD_W'(1);
				end
			end
			ST_MON2: begin
				if (add_en)
					m_q <= m_q + FIELD_W'(1);
			end
			default: begin
			end
		endcase
	end

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DA1 || state_q == ST_DA2 || state_q == ST_DB1 ||
			state_q == ST_DB2 || state_q == ST_DY))
		else $error("divider finished outside a wait step");

	a_fin_posts_result: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> (out_valid_q && state_q == ST_IDLE))
		else $error("final step did not post a result");

	a_year_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_YEAR) |-> (y1_q <= y2_q))
		else $error("year walk passed the later year");

	a_cycle_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HEAD || state_q == ST_MON1 || state_q == ST_YEAR ||
			state_q == ST_MON2) |-> (c400_q < CYCLE_YEARS))
		else $error("year position left the 400-year cycle");

endmodule

/* tb/day_span_board_pkg.sv */
// Day span predictor and result scoreboard for the Gregorian day span testbench.
// Depends on gdds_pkg for the date and count widths; used by gregorian_date_day_span_top_tb.
package day_span_board_pkg;

	typedef struct {
		logic [gdds_pkg::DATE_W-1:0]  date_a;
		logic [gdds_pkg::DATE_W-1:0]  date_b;
		logic [gdds_pkg::COUNT_W-1:0] span;
	} span_entry_t;

	function automatic bit is_leap_year(input longint y);
		if (y % 100 == 0)
			return (y % 400) == 0;
		return (y % 4) == 0;
	endfunction

	// Months outside 1..12 count as 30 days.
	function automatic longint month_days(input longint m, input longint y);
		if (m == 2)
			return is_leap_year(y) ? 29 : 28;
		if (m == 1 || m == 3 || m == 5 || m == 7 || m == 8 || m == 10 || m == 12)
			return 31;
		return 30;
	endfunction

	// Leap years in [0, y); year 0 is a leap year.
	function automatic longint leap_years_below(input longint y);
		longint p;
		if (y <= 0)
			return 0;
		p = y - 1;
		return p / 4 - p / 100 + p / 400 + 1;
	endfunction

	class day_span_board;
		span_entry_t pending_spans[$];
		int unsigned requests;
		int unsigned results;
		int unsigned mismatches;

		function logic [gdds_pkg::COUNT_W-1:0] inclusive_span(
			input logic [gdds_pkg::DATE_W-1:0] a,
			input logic [gdds_pkg::DATE_W-1:0] b);
			longint lo, hi, y1, m1, d1, y2, m2, d2, m, total;
			if (a > b) begin
				lo = longint'(b);
				hi = longint'(a);
			end else begin
				lo = longint'(a);
				hi = longint'(b);
			end
			d1 = lo % 100;
			m1 = (lo / 100) % 100;
			y1 = lo / 10000;
			d2 = hi % 100;
			m2 = (hi / 100) % 100;
			y2 = hi / 10000;
			total = 0;
			if (y1 < y2) begin
				// Rest of the first year, then every whole year in between.
				total += month_days(m1, y1) - d1;
				for (m = m1 + 1; m <= 12; m++)
					total += month_days(m, y1);
				total += 1;
				total += 365 * (y2 - y1 - 1) + leap_years_below(y2) - leap_years_below(y1 + 1);
				m1 = 1;
				d1 = 1;
				y1 = y2;
			end
			for (m = m1; m < m2; m++)
				total += month_days(m, y1);
			total += d2 - d1 + 1;
			return total[gdds_pkg::COUNT_W-1:0];
		endfunction

		function void note_request(input logic [gdds_pkg::DATE_W-1:0] a,
			input logic [gdds_pkg::DATE_W-1:0] b);
			span_entry_t e;
			e.date_a = a;
			e.date_b = b;
			e.span   = inclusive_span(a, b);
			pending_spans.push_back(e);
			requests++;
		endfunction

		function void check_count(input logic [gdds_pkg::COUNT_W-1:0] actual);
			span_entry_t e;
			results++;
			if (pending_spans.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected day_count: expected nothing, actual %0d",
					$realtime, actual);
				return;
			end
			e = pending_spans.pop_front();
			if (actual !== e.span) begin
				mismatches++;
				$display("%0t: day_count for %0d and %0d: expected %0d, actual %0d",
					$realtime, e.date_a, e.date_b, e.span, actual);
			end
		endfunction
	endclass

endpackage

/* tb/gregorian_date_day_span_top_tb.sv */
// Self-checking testbench for gregorian_date_day_span_top.
// Depends on gdds_pkg and day_span_board_pkg; drives requests and checks day counts.
module gregorian_date_day_span_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import day_span_board_pkg::*;

	localparam int DW = gdds_pkg::DATE_W;
	localparam int CW = gdds_pkg::COUNT_W;
	localparam logic [DW-1:0] DATE_MAX = '1;
	// Allow several times the longest year walk.
	localparam int QUIET_LIMIT = 80000;
	localparam int DRAIN_CYCLES = 300;
	localparam int RANDOM_PER_PHASE = 20;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	logic [DW-1:0] first_date;
	logic [DW-1:0] second_date;
	logic          out_valid;
	logic          out_ready;
	logic [CW-1:0] day_count;

	day_span_board board;
	int unsigned   sender_idle_pct;
	int unsigned   receiver_stall_pct;
	int unsigned   quiet_cycles;

	gregorian_date_day_span_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.first_date (first_date),
		.second_date(second_date),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.day_count  (day_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The receiver decides each cycle whether to stall. Everything below samples
	// at the rising edge, so it sees the values that the block saw.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// Every result that leaves the block is compared against the oldest request
	// that is still waiting for its answer.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_count(day_count);
	end

	// The watchdog counts cycles in which neither channel moves anything. A
	// correct block never goes quiet for longer than one wide year walk.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
				$display("Mismatches found");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Present one request and hold it until the block takes it. The task is
	// entered and left at a rising edge; valid is only lowered when the sender
	// idles or stops sending, so a back-to-back request never sees valid drop.
	task automatic send_request(input logic [DW-1:0] a, input logic [DW-1:0] b);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		first_date  <= a;
		second_date <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_request(a, b);
	endtask

	// Stop sending and wait until every request has been answered.
	task automatic wait_until_answered();
		in_valid <= 1'b0;
		while (board.pending_spans.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [DW-1:0] pack_date(input int unsigned y, input int unsigned m,
		input int unsigned d);
		logic [31:0] v;
		v = y * 10000 + m * 100 + d;
		if (v > DATE_MAX)
			v = DATE_MAX - $urandom_range(0, 1000);
		return v[DW-1:0];
	endfunction

	function automatic logic [DW-1:0] calendar_date(input int unsigned y);
		int unsigned m;
		m = $urandom_range(1, 12);
		return pack_date(y, m, $urandom_range(1, int'(month_days(longint'(m), longint'(y)))));
	endfunction

	// Most pairs are real calendar dates within three decades of each other, which keeps the
	// year walk short. Some carry bogus month and day fields, a few are raw bit
	// patterns, and a few are real dates anywhere in the four-digit range.
	task automatic make_random_pair(output logic [DW-1:0] a, output logic [DW-1:0] b);
		int unsigned kind, y1, y2;
		logic [DW-1:0] t;
		kind = $urandom_range(0, 99);
		y1   = $urandom_range(0, 9999);
		if (kind < 70) begin
			y2 = y1 + $urandom_range(0, 30);
			a  = calendar_date(y1);
			b  = calendar_date(y2);
		end else if (kind < 85) begin
			y2 = y1 + $urandom_range(0, 5);
			a  = pack_date(y1, $urandom_range(0, 99), $urandom_range(0, 99));
			b  = pack_date(y2, $urandom_range(0, 99), $urandom_range(0, 99));
		end else if (kind < 93) begin
			a = DW'($urandom());
			b = DW'($urandom());
		end else begin
			a = calendar_date(y1);
			b = calendar_date($urandom_range(0, 9999));
		end
		if ($urandom_range(0, 1) == 1) begin
			t = a;
			a = b;
			b = t;
		end
	endtask

	initial begin
		logic [DW-1:0] a, b;
		board              = new();
		arst_n             = 1'b0;
		in_valid           = 1'b0;
		first_date         = '0;
		second_date        = '0;
		out_ready          = 1'b0;
		quiet_cycles       = 0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: equal dates, all-zero and all-ones fields, the
		// leap rules around February, reversed order, bogus months and days,
		// and spans that go negative or overflow the count and wrap.
		send_request(27'd20200101, 27'd20200101);
		send_request(27'd0, 27'd0);
		send_request(27'd0, DATE_MAX);
		send_request(DATE_MAX, 27'd0);
		send_request(DATE_MAX, DATE_MAX);
		send_request(27'd20000228, 27'd20000301);
		send_request(27'd19000228, 27'd19000301);
		send_request(27'd24000101, 27'd24001231);
		send_request(27'd21000201, 27'd21000301);
		send_request(27'd20240229, 27'd20240301);
		send_request(27'd00000228, 27'd00000301);
		send_request(27'd19991231, 27'd20000101);
		send_request(27'd20210315, 27'd20200101);
		send_request(27'd20200010, 27'd20200305);
		send_request(27'd20201310, 27'd20210105);
		send_request(27'd20209915, 27'd20209920);
		send_request(27'd20200500, 27'd20200599);
		send_request(27'd20200199, 27'd20200200);
		send_request(27'd20201399, 27'd20210100);
		send_request(27'd00010101, 27'd99991231);
		send_request(27'd67108864, 27'd67108863);
		send_request(27'd19700101, 27'd20380119);

		// Hold off here until the directed results are all back, so the next
		// request meets an empty pipeline.
		wait_until_answered();

		// Random requests in four handshake phases: no idling, an idle sender,
		// a stalling receiver, and both at once.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct    = 46;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 46;
				end
				default: begin
					sender_idle_pct    = 24;
					receiver_stall_pct = 24;
				end
			endcase
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				make_random_pair(a, b);
				send_request(a, b);
			end
			if (phase == 1)
				wait_until_answered();
		end

		wait_until_answered();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d date pairs (corner cases and random spans), checked %0d counts",
			board.requests, board.results);
		$display("under four sender and receiver idling patterns; %0d mismatched.",
			board.mismatches);
		if (board.mismatches == 0 && board.pending_spans.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* gregorian_date_day_span_top.f */
hw/rtl/gdds_pkg.sv
hw/rtl/gdds_div.sv
hw/rtl/gregorian_date_day_span_top.sv
tb/day_span_board_pkg.sv
tb/gregorian_date_day_span_top_tb.sv
